// ===== rtl/nlrt_pkg.sv =====
// nlrt_pkg: shared types and constants of the namespace LBA range table
// transaction structs, command and status codes, register indexes, slot entry layout
// depends on nothing

package nlrt_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int LBA_W  = 48;
  localparam int ID_W   = 32;
  localparam int MODE_W = 2;

  localparam logic [LBA_W+1:0] LBA_LIMIT = {2'b01, {LBA_W{1'b0}}};

  localparam logic [1:0] CMD_CREATE   = 2'd0;
  localparam logic [1:0] CMD_DELETE   = 2'd1;
  localparam logic [1:0] CMD_GET_INFO = 2'd2;
  localparam logic [1:0] CMD_FORMAT   = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_INVALID  = 3'd1;
  localparam logic [2:0] ST_EXISTS   = 3'd2;
  localparam logic [2:0] ST_NOSPACE  = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_MODE = 1'b1;

  localparam logic [LBA_W-1:0] CAPACITY_RESET = 48'd16777216;

  typedef struct packed {
    logic [1:0]        command;
    logic [ID_W-1:0]   namespace_id;
    logic [LBA_W-1:0]  request_count;
  } cmd_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [ID_W-1:0]   info_id;
    logic [LBA_W-1:0]  info_start;
    logic [LBA_W-1:0]  info_count;
    logic [MODE_W-1:0] info_mode;
    logic [4:0]        live_namespaces;
    logic [LBA_W-1:0]  unallocated_lbas;
  } rsp_t;

  typedef struct packed {
    logic [LBA_W-1:0]  capacity_lbas;
    logic [MODE_W-1:0] default_mode;
  } cfg_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LBA_W-1:0]  start;
    logic [LBA_W-1:0]  count;
    logic [MODE_W-1:0] mode;
  } slot_t;

  localparam int SLOT_BITS = $bits(slot_t);

endpackage

// ===== rtl/nlrt_ram.sv =====
// nlrt_ram: generic single-port-write, single-port-read ram with registered read
// depends on nothing

module nlrt_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/nlrt_ctrl.sv =====
// nlrt_ctrl: command sequencer of the namespace table
// scans the slot ram, decides the command, writes back and holds the result register
// depends on nlrt_pkg and on a slot ram instance in the top level

module nlrt_ctrl (
  input  logic                         clk,
  input  logic                         rst,
  input  nlrt_pkg::cfg_t               cfg,
  input  logic                         cmd_valid,
  output logic                         cmd_stall,
  input  nlrt_pkg::cmd_t               cmd,
  output logic                         rsp_valid,
  input  logic                         rsp_stall,
  output nlrt_pkg::rsp_t               rsp,
  output logic                         ram_we,
  output logic [nlrt_pkg::SLOT_W-1:0]  ram_waddr,
  output nlrt_pkg::slot_t              ram_wdata,
  output logic                         ram_re,
  output logic [nlrt_pkg::SLOT_W-1:0]  ram_raddr,
  input  nlrt_pkg::slot_t              ram_rdata
);
  import nlrt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_DONE   = 5'b01000,
    S_SPARE  = 5'b10000
  } state_t;

  state_t              state;
  state_t              state_next;
  logic [CNT_W-1:0]    addr;
  logic [SLOT_W-1:0]   prev_idx;
  cmd_t                cmd_q;
  logic                found;
  logic [SLOT_W-1:0]   hit_idx;
  slot_t               hit_data;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic [LBA_W:0]      top;
  logic [NUM_SLOTS-1:0] active;
  logic [LBA_W-1:0]    alloc;
  logic [CNT_W-1:0]    active_cnt;
  rsp_t                res;
  rsp_t                res_next;
  rsp_t                rsp_next;

  logic                scan_first;
  logic                scan_last;
  logic                entry_active;
  logic                entry_hit;
  logic [LBA_W:0]      entry_end;
  logic [LBA_W:0]      alloc_sum;
  logic [LBA_W+1:0]    end_sum;
  logic                invalid;
  logic [2:0]          dec_status;
  logic                do_create;
  logic                do_delete;
  logic                rsp_free;

  assign cmd_stall    = (state != S_IDLE);
  assign scan_first   = (addr == '0);
  assign scan_last    = (addr == CNT_W'(NUM_SLOTS));
  assign ram_re       = (state == S_SCAN) && !scan_last;
  assign ram_raddr    = addr[SLOT_W-1:0];
  assign entry_active = active[prev_idx];
  assign entry_hit    = entry_active && (ram_rdata.id == cmd_q.namespace_id);
  assign entry_end    = {1'b0, ram_rdata.start} + {1'b0, ram_rdata.count};
  assign rsp_free     = !rsp_valid || !rsp_stall;

  assign alloc_sum = {1'b0, alloc} + {1'b0, cmd_q.request_count};
  assign end_sum   = {1'b0, top} + {2'b00, cmd_q.request_count};
  assign invalid   = (cmd_q.namespace_id == '0) ||
                     ((cmd_q.command == CMD_CREATE) && (cmd_q.request_count == '0));

  always_comb begin
    dec_status = ST_OK;
    do_create  = 1'b0;
    do_delete  = 1'b0;
    if (invalid) begin
      dec_status = ST_INVALID;
    end else begin
      case (cmd_q.command)
        CMD_CREATE: begin
          if (found) begin
            dec_status = ST_EXISTS;
          end else if (alloc_sum > {1'b0, cfg.capacity_lbas}) begin
            dec_status = ST_NOSPACE;
          end else if (!free_found) begin
            dec_status = ST_NOSPACE;
          end else if (end_sum > LBA_LIMIT) begin
            dec_status = ST_NOSPACE;
          end else begin
            do_create = 1'b1;
          end
        end
        default: begin
          if (!found) begin
            dec_status = ST_NOTFOUND;
          end else if (cmd_q.command == CMD_DELETE) begin
            do_delete = 1'b1;
          end
        end
      endcase
    end
  end

  always_comb begin
    res_next        = '0;
    res_next.status = dec_status;
    if (!invalid && found && (cmd_q.command == CMD_GET_INFO)) begin
      res_next.info_id    = hit_data.id;
      res_next.info_start = hit_data.start;
      res_next.info_count = hit_data.count;
      res_next.info_mode  = hit_data.mode;
    end
  end

  always_comb begin
    rsp_next                  = res;
    rsp_next.live_namespaces  = 5'(active_cnt);
    rsp_next.unallocated_lbas = (alloc >= cfg.capacity_lbas) ? '0
                                : (cfg.capacity_lbas - alloc);
  end

  assign ram_we          = (state == S_DECIDE) && do_create;
  assign ram_waddr       = free_idx;
  assign ram_wdata.id    = cmd_q.namespace_id;
  assign ram_wdata.start = top[LBA_W-1:0];
  assign ram_wdata.count = cmd_q.request_count;
  assign ram_wdata.mode  = cfg.default_mode;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (rsp_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= '0;
      alloc      <= '0;
      active_cnt <= '0;
      rsp_valid  <= 1'b0;
      addr       <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          addr       <= '0;
          found      <= 1'b0;
          free_found <= 1'b0;
        end
        S_SCAN: begin
          addr <= addr + CNT_W'(1);
          if (!scan_first) begin
            if (entry_hit && !found) begin
              found <= 1'b1;
            end
            if (!entry_active && !free_found) begin
              free_found <= 1'b1;
            end
          end
        end
        S_DECIDE: begin
          if (do_create) begin
            active[free_idx] <= 1'b1;
            alloc            <= alloc_sum[LBA_W-1:0];
            active_cnt       <= active_cnt + CNT_W'(1);
          end else if (do_delete) begin
            active[hit_idx]  <= 1'b0;
            alloc            <= alloc - hit_data.count;
            active_cnt       <= active_cnt - CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
      if (state == S_DONE && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    prev_idx <= addr[SLOT_W-1:0];
    if (state == S_IDLE && cmd_valid) begin
      cmd_q <= cmd;
      top   <= '0;
    end
    if (state == S_SCAN && !scan_first) begin
      if (entry_hit && !found) begin
        hit_idx  <= prev_idx;
        hit_data <= ram_rdata;
      end
      if (!entry_active && !free_found) begin
        free_idx <= prev_idx;
      end
      if (entry_active && (entry_end > top)) begin
        top <= entry_end;
      end
    end
    if (state == S_DECIDE) begin
      res <= res_next;
    end
    if (state == S_DONE && rsp_free) begin
      rsp <= rsp_next;
    end
  end

endmodule

// ===== rtl/namespace_lba_range_table.sv =====
// Namespace LBA range table: NUM_SLOTS slots of id, start LBA, LBA count and pool mode in a
// synchronous ram, with the active flags, allocated total and live count in flip-flops.
// One command is handled at a time: the sequencer reads every slot through the single ram
// read port, decides and writes back, and takes the next command only once the result has
// moved into the result register. The result register lets the next command start while a
// result still waits. The user must write configuration only while the block is idle; the
// block itself does not enforce this.

module namespace_lba_range_table (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [nlrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [nlrt_pkg::LBA_W-1:0]       cfg_data,
  input  logic                             cmd_valid,
  output logic                             cmd_stall,
  input  nlrt_pkg::cmd_t                   cmd,
  output logic                             rsp_valid,
  input  logic                             rsp_stall,
  output nlrt_pkg::rsp_t                   rsp
);
  import nlrt_pkg::*;

  cfg_t              cfg;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_t             ram_wdata;
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  slot_t             ram_rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.capacity_lbas <= CAPACITY_RESET;
      cfg.default_mode  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAPACITY:     cfg.capacity_lbas <= cfg_data;
        CFG_DEFAULT_MODE: cfg.default_mode  <= cfg_data[MODE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  nlrt_ram #(
    .WIDTH  (SLOT_BITS),
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (SLOT_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nlrt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule

// ===== rtl/nlrt_checker.sv =====
// nlrt_checker: port-level assertions for the namespace LBA range table
// depends on nlrt_pkg; bound to the top level at the end of this file

module nlrt_checker (
  input logic           clk,
  input logic           rst,
  input logic           cmd_valid,
  input logic           cmd_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input nlrt_pkg::rsp_t rsp
);
  import nlrt_pkg::*;

  // held result stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one command at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> cmd_stall)
    else $error("command taken while another is in progress");

  a_info_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status != ST_OK) |->
      (rsp.info_id == '0) && (rsp.info_start == '0) &&
      (rsp.info_count == '0) && (rsp.info_mode == '0))
    else $error("info fields set on a failed command");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status <= ST_NOTFOUND) &&
                  (32'(rsp.live_namespaces) <= 32'(NUM_SLOTS)))
    else $error("status or live count out of range");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !rsp_valid && !cmd_stall)
    else $error("not idle after reset");

endmodule

bind namespace_lba_range_table nlrt_checker u_checker (.*);
